// ----- src/gle_pkg.sv -----
package gle_pkg;

    localparam int CODE_W           = 12;
    localparam int ACC_W            = 20;
    localparam int LINK_W           = 13;
    localparam int KEY_W            = 20;
    localparam int MAX_CODES        = 4096;
    localparam int DEF_HASH_BUCKETS = 8192;

    localparam logic [CODE_W-1:0] CLEAR_CODE = 12'd256;
    localparam logic [CODE_W-1:0] END_CODE   = 12'd257;
    localparam logic [CODE_W-1:0] FIRST_FREE = 12'd258;
    localparam logic [CODE_W-1:0] FULL_MARK  = 12'd4094;
    localparam logic [3:0]        MIN_WIDTH  = 4'd9;
    localparam logic [3:0]        TOP_WIDTH  = 4'd12;

    typedef enum logic [3:0] {
        ST_CLEARING,
        ST_IDLE,
        ST_START,
        ST_TAIL,
        ST_HEAD_RD,
        ST_HEAD_CHK,
        ST_PAIR_CHK,
        ST_MISS_SEND,
        ST_ADD,
        ST_FULL_CLR,
        ST_LAST_PFX,
        ST_LAST_END,
        ST_DRAIN,
        ST_FLUSH
    } state_t;

    typedef enum logic [1:0] {
        SEL_PREFIX,
        SEL_CLEAR,
        SEL_END
    } code_sel_t;

    typedef struct packed {
        logic      take;
        logic      start;
        logic      head_rd;
        logic      head_latch;
        logic      head_follow;
        logic      pair_follow;
        logic      hit;
        logic      send;
        code_sel_t sel;
        logic      add;
        logic      full_clr;
        logic      push;
        logic      push_last;
        logic      flush;
        logic      finish;
        logic      clr_wr;
    } cmd_t;

    typedef struct packed {
        logic in_valid;
        logic in_image;
        logic last;
        logic head_valid;
        logic hit;
        logic follow;
        logic full;
        logic cnt_ge8;
        logic cnt_eq8;
        logic cnt_nz;
        logic out_free;
        logic clr_last;
    } sts_t;

endpackage

// ----- src/gle_pix_if.sv -----
interface gle_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_index;
    logic       last_pixel;

    modport source (output valid, output pixel_index, output last_pixel, input ready);
    modport sink (input valid, input pixel_index, input last_pixel, output ready);
endinterface

// ----- src/gle_byte_if.sv -----
interface gle_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- src/gle_ram.sv -----
module gle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- src/gle_ctrl.sv -----
module gle_ctrl
    import gle_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEARING;
            ret_reg   <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        unique case (state_reg)
            ST_CLEARING:
            begin
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (sts.in_valid)
                begin
                    state_next = sts.in_image ? ST_HEAD_RD : ST_START;
                end
            end
            ST_START:
            begin
                state_next = ST_DRAIN;
                ret_next   = ST_TAIL;
            end
            ST_TAIL:
            begin
                state_next = sts.last ? ST_LAST_PFX : ST_IDLE;
            end
            ST_HEAD_RD:
            begin
                state_next = ST_HEAD_CHK;
            end
            ST_HEAD_CHK:
            begin
                state_next = sts.head_valid ? ST_PAIR_CHK : ST_MISS_SEND;
            end
            ST_PAIR_CHK:
            begin
                priority if (sts.hit)
                begin
                    state_next = ST_TAIL;
                end
                else if (sts.follow)
                begin
                    state_next = ST_PAIR_CHK;
                end
                else
                begin
                    state_next = ST_MISS_SEND;
                end
            end
            ST_MISS_SEND:
            begin
                state_next = ST_DRAIN;
                ret_next   = ST_ADD;
            end
            ST_ADD:
            begin
                state_next = sts.full ? ST_FULL_CLR : ST_TAIL;
            end
            ST_FULL_CLR:
            begin
                state_next = ST_DRAIN;
                ret_next   = ST_TAIL;
            end
            ST_LAST_PFX:
            begin
                state_next = ST_DRAIN;
                ret_next   = ST_LAST_END;
            end
            ST_LAST_END:
            begin
                state_next = ST_DRAIN;
                ret_next   = ST_FLUSH;
            end
            ST_DRAIN:
            begin
                if (!sts.cnt_ge8)
                begin
                    state_next = ret_reg;
                end
            end
            ST_FLUSH:
            begin
                if (!sts.cnt_nz || sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.sel = SEL_PREFIX;
        unique case (state_reg)
            ST_CLEARING:  cmd.clr_wr = 1'b1;
            ST_IDLE:      cmd.take = 1'b1;
            ST_START:     cmd.start = 1'b1;
            ST_TAIL:      cmd.take = 1'b0;
            ST_HEAD_RD:   cmd.head_rd = 1'b1;
            ST_HEAD_CHK:
            begin
                cmd.head_latch  = 1'b1;
                cmd.head_follow = sts.head_valid;
            end
            ST_PAIR_CHK:
            begin
                cmd.hit         = sts.hit;
                cmd.pair_follow = !sts.hit && sts.follow;
            end
            ST_MISS_SEND: cmd.send = 1'b1;
            ST_ADD:       cmd.add = 1'b1;
            ST_FULL_CLR:
            begin
                cmd.send     = 1'b1;
                cmd.sel      = SEL_CLEAR;
                cmd.full_clr = 1'b1;
            end
            ST_LAST_PFX:  cmd.send = 1'b1;
            ST_LAST_END:
            begin
                cmd.send = 1'b1;
                cmd.sel  = SEL_END;
            end
            ST_DRAIN:
            begin
                cmd.push      = sts.cnt_ge8 && sts.out_free;
                cmd.push_last = (ret_reg == ST_FLUSH) && sts.cnt_eq8;
            end
            ST_FLUSH:
            begin
                cmd.flush  = sts.cnt_nz && sts.out_free;
                cmd.finish = !sts.cnt_nz || sts.out_free;
            end
            default:      cmd.take = 1'b0;
        endcase
    end

endmodule

// ----- src/gle_dpath.sv -----
module gle_dpath
    import gle_pkg::*;
#(
    parameter int HASH_BUCKETS = DEF_HASH_BUCKETS
) (
    input  logic clk,
    input  logic rst_n,
    input  cmd_t cmd,
    output sts_t sts,
    gle_pix_if.sink    pixels,
    gle_byte_if.source bytes
);

    localparam int HB = $clog2(HASH_BUCKETS);
    localparam int CA = $clog2(MAX_CODES);

    function automatic logic [HB-1:0] bucket_of(input logic [KEY_W-1:0] key);
        return HB'(key) ^ HB'(key >> HB);
    endfunction

    logic [7:0]        pix_reg;
    logic              last_reg;
    logic [CODE_W-1:0] prefix_reg, prefix_next;
    logic [CODE_W-1:0] nfc_reg, nfc_next;
    logic [3:0]        width_reg, width_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic              in_image_reg, in_image_next;
    logic [LINK_W-1:0] head_link_reg;
    logic [CODE_W-1:0] cur_reg;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_data_reg;
    logic              out_last_reg;
    logic [HB-1:0]     clr_addr_reg;

    logic [KEY_W-1:0]  key;
    logic [HB-1:0]     bucket_cur;
    logic [LINK_W-1:0] head_rdata;
    logic [KEY_W-1:0]  pair_rdata;
    logic [LINK_W-1:0] chain_rdata;
    logic [CODE_W-1:0] head_code, chain_code, code, nfc_inc;
    logic              out_free, accept;

    assign key        = {prefix_reg, pix_reg};
    assign bucket_cur = bucket_of(key);
    assign head_code  = CODE_W'(head_rdata - LINK_W'(1));
    assign chain_code = CODE_W'(chain_rdata - LINK_W'(1));
    assign nfc_inc    = nfc_reg + CODE_W'(1);
    assign out_free   = !out_valid_reg || bytes.ready;
    assign accept     = pixels.valid && cmd.take;

    gle_ram #(.WIDTH(LINK_W), .DEPTH(2 ** HB)) u_heads (
        .clk     (clk),
        .wr_en   (cmd.add || cmd.clr_wr),
        .wr_addr (cmd.clr_wr ? clr_addr_reg : bucket_cur),
        .wr_data (cmd.clr_wr ? LINK_W'(0) : LINK_W'(nfc_inc)),
        .rd_en   (cmd.head_rd),
        .rd_addr (bucket_cur),
        .rd_data (head_rdata)
    );

    gle_ram #(.WIDTH(KEY_W), .DEPTH(MAX_CODES)) u_pairs (
        .clk     (clk),
        .wr_en   (cmd.add),
        .wr_addr (nfc_reg[CA-1:0]),
        .wr_data (key),
        .rd_en   (cmd.head_follow || cmd.pair_follow),
        .rd_addr (cmd.head_follow ? head_code[CA-1:0] : chain_code[CA-1:0]),
        .rd_data (pair_rdata)
    );

    gle_ram #(.WIDTH(LINK_W), .DEPTH(MAX_CODES)) u_links (
        .clk     (clk),
        .wr_en   (cmd.add),
        .wr_addr (nfc_reg[CA-1:0]),
        .wr_data (head_link_reg),
        .rd_en   (cmd.head_follow || cmd.pair_follow),
        .rd_addr (cmd.head_follow ? head_code[CA-1:0] : chain_code[CA-1:0]),
        .rd_data (chain_rdata)
    );

    always_comb
    begin
        unique case (cmd.sel)
            SEL_PREFIX: code = prefix_reg;
            SEL_CLEAR:  code = CLEAR_CODE;
            SEL_END:    code = END_CODE;
            default:    code = prefix_reg;
        endcase
    end

    always_comb
    begin
        prefix_next    = prefix_reg;
        nfc_next       = nfc_reg;
        width_next     = width_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        in_image_next  = in_image_reg;
        out_valid_next = out_valid_reg && !bytes.ready;
        if (cmd.start)
        begin
            nfc_next      = FIRST_FREE;
            width_next    = MIN_WIDTH;
            acc_next      = ACC_W'(CLEAR_CODE);
            cnt_next      = 5'(MIN_WIDTH);
            prefix_next   = CODE_W'(pix_reg);
            in_image_next = 1'b1;
        end
        if (cmd.send)
        begin
            acc_next = acc_reg | (ACC_W'(code) << cnt_reg);
            cnt_next = cnt_reg + 5'(width_reg);
        end
        if (cmd.hit)
        begin
            prefix_next = cur_reg;
        end
        if (cmd.add)
        begin
            nfc_next    = nfc_inc;
            prefix_next = CODE_W'(pix_reg);
            if ((13'(nfc_inc) > (13'd1 << width_reg)) && (width_reg < TOP_WIDTH))
            begin
                width_next = width_reg + 4'd1;
            end
        end
        if (cmd.full_clr)
        begin
            nfc_next   = FIRST_FREE;
            width_next = MIN_WIDTH;
        end
        if (cmd.push)
        begin
            acc_next       = acc_reg >> 8;
            cnt_next       = cnt_reg - 5'd8;
            out_valid_next = 1'b1;
        end
        if (cmd.flush)
        begin
            acc_next       = '0;
            cnt_next       = '0;
            out_valid_next = 1'b1;
        end
        if (cmd.finish)
        begin
            in_image_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg    <= '0;
            nfc_reg       <= FIRST_FREE;
            width_reg     <= MIN_WIDTH;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            in_image_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            clr_addr_reg  <= '0;
        end
        else
        begin
            prefix_reg    <= prefix_next;
            nfc_reg       <= nfc_next;
            width_reg     <= width_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            in_image_reg  <= in_image_next;
            out_valid_reg <= out_valid_next;
            if (cmd.clr_wr)
            begin
                clr_addr_reg <= clr_addr_reg + HB'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg  <= pixels.pixel_index;
            last_reg <= pixels.last_pixel;
        end
        if (cmd.head_latch)
        begin
            head_link_reg <= head_rdata;
        end
        if (cmd.head_follow)
        begin
            cur_reg <= head_code;
        end
        else if (cmd.pair_follow)
        begin
            cur_reg <= chain_code;
        end
        if (cmd.push || cmd.flush)
        begin
            out_data_reg <= acc_reg[7:0];
            out_last_reg <= cmd.flush || cmd.push_last;
        end
    end

    assign pixels.ready    = cmd.take;
    assign bytes.valid     = out_valid_reg;
    assign bytes.data_byte = out_data_reg;
    assign bytes.last_byte = out_last_reg;

    always_comb
    begin
        sts.in_valid   = pixels.valid;
        sts.in_image   = in_image_reg;
        sts.last       = last_reg;
        sts.head_valid = (head_rdata != '0) && (head_code >= FIRST_FREE)
                         && (head_code < nfc_reg);
        sts.hit        = (pair_rdata == key);
        sts.follow     = (bucket_of(pair_rdata) == bucket_cur) && (chain_rdata != '0)
                         && (chain_code >= FIRST_FREE) && (chain_code < cur_reg);
        sts.full       = (nfc_inc >= FULL_MARK);
        sts.cnt_ge8    = (cnt_reg >= 5'd8);
        sts.cnt_eq8    = (cnt_reg == 5'd8);
        sts.cnt_nz     = (cnt_reg != '0);
        sts.out_free   = out_free;
        sts.clr_last   = (clr_addr_reg == '1);
    end

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 5'd19)
        else $error("bit count out of range");
    a_width_range: assert property (@(posedge clk) disable iff (!rst_n)
        width_reg >= MIN_WIDTH && width_reg <= TOP_WIDTH)
        else $error("code width out of range");
    a_nfc_range: assert property (@(posedge clk) disable iff (!rst_n)
        nfc_reg >= FIRST_FREE && nfc_reg <= FULL_MARK)
        else $error("next free code out of range");
    a_full_resets: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.add && sts.full |=> ##1 nfc_reg == FIRST_FREE)
        else $error("dictionary not reset when full");
`endif

endmodule

// ----- src/gif_lzw_encoder_top.sv -----
// GIF LZW encoder with variable code width, 9 to 12 bits.
// Pixels enter on the pixels channel (pixel_index, last_pixel); a transfer
// happens when valid and ready are both high. Packed code-stream bytes leave
// on the bytes channel (data_byte, last_byte), least significant bit first.
// The first pixel of an image emits the clear code; the last one emits the
// pending code, the end code and the partial byte, marked by last_byte.
// One pixel is processed at a time. A pixel that extends a known string goes
// through a hash head read, a head check and one pair check per hash chain
// entry examined; a pixel that adds a dictionary entry also sends the prefix
// code, drains its full bytes and writes the new entry. The first pixel of an
// image sends the clear code without a lookup; a full dictionary also sends
// the clear code, and the last pixel sends the pending code and the end code.
// The hash chain walk through the dictionary memories sets how long a pixel takes.
// After reset the block clears its hash bucket memory, one entry per cycle;
// pixels are not taken during that time.
// Bytes sit in one output register; when the receiver stalls, the encoder
// waits at the next byte and stops taking pixels until the byte is moved.
module gif_lzw_encoder_top
    import gle_pkg::*;
#(
    parameter int HASH_BUCKETS = DEF_HASH_BUCKETS
) (
    input logic        clk,
    input logic        rst_n,
    gle_pix_if.sink    pixels,
    gle_byte_if.source bytes
);

    cmd_t cmd;
    sts_t sts;

    gle_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    gle_dpath #(.HASH_BUCKETS(HASH_BUCKETS)) u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .sts    (sts),
        .pixels (pixels),
        .bytes  (bytes)
    );

endmodule
